// ----- hdl/wupf_pkg.sv -----
// Shared types and constants for the UDP push frame filter.
// Item structs, APB request struct, reject codes and header constants.
// No dependencies.
package wupf_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_UDP_PORT = 1'b0;
   localparam logic [15:0] UDP_PORT_RESET = 16'd1700;

   localparam int BASE_HDR_LEN = 24;
   localparam int QOS_HDR_EXTRA = 2;
   localparam int SNAP_LEN = 8;
   localparam int UDP_HDR_LEN = 8;
   localparam int PUSH_HDR_LEN = 12;
   localparam int MIN_FRAME_LEN = 72;
   localparam int MSG_ID_OFFSET = 3;
   localparam int IP_PROTO_OFFSET = 9;
   localparam int ETHER_HI_OFFSET = 6;
   localparam int ETHER_LO_OFFSET = 7;
   localparam int DPORT_HI_OFFSET = 2;
   localparam int DPORT_LO_OFFSET = 3;

   localparam logic [7:0] SNAP_DSAP = 8'hAA;
   localparam logic [7:0] SNAP_CTRL = 8'h03;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0] IP_VERSION4 = 4'd4;
   localparam logic [7:0] IP_PROTO_UDP = 8'd17;
   localparam logic [1:0] FC_TYPE_DATA = 2'b10;

   typedef enum logic [3:0] {
      REASON_OK         = 4'd0,
      REASON_KIND       = 4'd1,
      REASON_BUSY       = 4'd2,
      REASON_SHORT      = 4'd3,
      REASON_TYPE       = 4'd4,
      REASON_SNAP       = 4'd5,
      REASON_ETHERTYPE  = 4'd6,
      REASON_VERSION    = 4'd7,
      REASON_PROTO      = 4'd8,
      REASON_UDP_BOUNDS = 4'd9,
      REASON_PORT       = 4'd10,
      REASON_PAY_SHORT  = 4'd11,
      REASON_IDENT      = 4'd12
   } reason_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
      logic       packet_is_data;
      logic       slot_busy;
   } req_item_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic       payload_write;
      logic       frame_done;
      logic       matched;
      logic [3:0] reject_reason;
      logic [7:0] captured_length;
   } rsp_item_type;

   typedef struct packed {
      logic                  psel;
      logic                  penable;
      logic                  pwrite;
      logic [CSR_ADDR_W-1:0] paddr;
      logic [CSR_DATA_W-1:0] pwdata;
   } apb_req_type;

endpackage

// ----- hdl/wupf_csr.sv -----
// Configuration register file: holds the destination UDP port.
// Depends on wupf_pkg.
module wupf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  wupf_pkg::apb_req_type           apb_req,
   output logic [wupf_pkg::CSR_DATA_W-1:0] prdata,
   output logic [15:0]                     udp_port
);
   import wupf_pkg::*;

   logic [15:0] udp_port_ff;
   logic [15:0] udp_port_in;
   logic        sel_port;

   assign sel_port = (apb_req.paddr[CSR_ADDR_W-1] == CSR_IDX_UDP_PORT);

   always_comb begin
      udp_port_in = udp_port_ff;
      if (apb_req.psel && apb_req.penable && apb_req.pwrite && sel_port) begin
         udp_port_in = apb_req.pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         udp_port_ff <= UDP_PORT_RESET;
      end else begin
         udp_port_ff <= udp_port_in;
      end
   end

   assign prdata   = sel_port ? {{(CSR_DATA_W-16){1'b0}}, udp_port_ff} : '0;
   assign udp_port = udp_port_ff;

endmodule

// ----- hdl/wupf_check.sv -----
// Frame checker: byte position tracking, header field capture and verdict.
// Result for the current item is combinational; field state updates on step.
// Depends on wupf_pkg.
module wupf_check #(
   parameter int CAPTURE_BYTES   = 220,
   parameter int MAX_FRAME_BYTES = 4095
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  wupf_pkg::req_item_type item,
   input  logic [15:0]            udp_port,
   output wupf_pkg::rsp_item_type result
);
   import wupf_pkg::*;

   localparam int CW   = $clog2(MAX_FRAME_BYTES + 1);
   localparam int CAPW = $clog2(CAPTURE_BYTES + 1);
   localparam int XW   = ((CW > CAPW) ? CW : CAPW) + 1;

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    fc_ff, fc_in;
   logic          snap_ff, snap_in;
   logic [15:0]   ether_ff, ether_in;
   logic [7:0]    ipf_ff, ipf_in;
   logic [7:0]    proto_ff, proto_in;
   logic [15:0]   dport_ff, dport_in;
   logic [7:0]    msg_ff, msg_in;
   logic [1:0]    early_ff, early_in;

   logic [CW-1:0] pos;
   logic          below_max;
   logic [XW-1:0] posx, hdr, ipoff, udpoff, ps, len, pl, pay_off, cap;
   logic [7:0]    b;
   logic          write;
   reason_type    reason;

   assign b = item.data_byte;

   always_comb begin
      early_in = item.first_byte ? {item.slot_busy, ~item.packet_is_data} : early_ff;
      pos      = item.first_byte ? '0 : count_ff;
      posx     = {{(XW-CW){1'b0}}, pos};

      fc_in = (pos == '0) ? b : fc_ff;
      hdr   = fc_in[7] ? XW'(BASE_HDR_LEN + QOS_HDR_EXTRA) : XW'(BASE_HDR_LEN);

      // SNAP flag: set on the first byte, knocked down by either later byte
      snap_in = snap_ff;
      if (posx == hdr) begin
         snap_in = (b == SNAP_DSAP);
      end
      if (posx == hdr + XW'(1) && b != SNAP_DSAP) begin
         snap_in = 1'b0;
      end
      if (posx == hdr + XW'(2) && b != SNAP_CTRL) begin
         snap_in = 1'b0;
      end

      ether_in = ether_ff;
      if (posx == hdr + XW'(ETHER_HI_OFFSET)) begin
         ether_in = {b, ether_ff[7:0]};
      end
      if (posx == hdr + XW'(ETHER_LO_OFFSET)) begin
         ether_in = {ether_ff[15:8], b};
      end

      ipoff    = hdr + XW'(SNAP_LEN);
      ipf_in   = (posx == ipoff) ? b : ipf_ff;
      proto_in = (posx == ipoff + XW'(IP_PROTO_OFFSET)) ? b : proto_ff;

      // IHL taken as is, no range check
      udpoff = ipoff + {{(XW-6){1'b0}}, ipf_in[3:0], 2'b00};

      dport_in = dport_ff;
      if (posx == udpoff + XW'(DPORT_HI_OFFSET)) begin
         dport_in = {b, dport_ff[7:0]};
      end
      if (posx == udpoff + XW'(DPORT_LO_OFFSET)) begin
         dport_in = {dport_ff[15:8], b};
      end

      ps     = udpoff + XW'(UDP_HDR_LEN);
      msg_in = (posx == ps + XW'(MSG_ID_OFFSET)) ? b : msg_ff;

      below_max = (pos < CW'(MAX_FRAME_BYTES));
      pay_off   = posx - ps;
      write     = below_max && (posx >= ps) && (pay_off < XW'(CAPTURE_BYTES));

      // saturate the byte counter
      count_in = below_max ? pos + CW'(1) : pos;
      len      = {{(XW-CW){1'b0}}, count_in};
      pl       = len - ps;

      reason = REASON_OK;
      if (early_in[0]) begin
         reason = REASON_KIND;
      end else if (early_in[1]) begin
         reason = REASON_BUSY;
      end else if (len < XW'(MIN_FRAME_LEN)) begin
         reason = REASON_SHORT;
      end else if (fc_in[3:2] != FC_TYPE_DATA) begin
         reason = REASON_TYPE;
      end else if (!snap_in) begin
         reason = REASON_SNAP;
      end else if (ether_in != ETHERTYPE_IPV4) begin
         reason = REASON_ETHERTYPE;
      end else if (ipf_in[7:4] != IP_VERSION4) begin
         reason = REASON_VERSION;
      end else if (proto_in != IP_PROTO_UDP) begin
         reason = REASON_PROTO;
      end else if (ps > len) begin
         reason = REASON_UDP_BOUNDS;
      end else if (dport_in != udp_port) begin
         reason = REASON_PORT;
      end else if (pl < XW'(PUSH_HDR_LEN)) begin
         reason = REASON_PAY_SHORT;
      end else if (msg_in != 8'd0) begin
         reason = REASON_IDENT;
      end

      cap = (pl < XW'(CAPTURE_BYTES)) ? pl : XW'(CAPTURE_BYTES);

      result.payload_byte    = b;
      result.payload_index   = write ? pay_off[7:0] : 8'd0;
      result.payload_write   = write;
      result.frame_done      = item.last_byte;
      result.matched         = item.last_byte && (reason == REASON_OK);
      result.reject_reason   = item.last_byte ? reason : REASON_OK;
      result.captured_length = (item.last_byte && reason == REASON_OK) ? cap[7:0] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fc_ff    <= '0;
         snap_ff  <= 1'b0;
         ether_ff <= '0;
         ipf_ff   <= '0;
         proto_ff <= '0;
         dport_ff <= '0;
         msg_ff   <= '0;
         early_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
         fc_ff    <= fc_in;
         snap_ff  <= snap_in;
         ether_ff <= ether_in;
         ipf_ff   <= ipf_in;
         proto_ff <= proto_in;
         dport_ff <= dport_in;
         msg_ff   <= msg_in;
         early_ff <= early_in;
      end
   end

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_FRAME_BYTES))
      else $error("byte counter past saturation limit");

   count_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(count_ff) && $stable(early_ff))
      else $error("frame state moved without a step");

   first_restarts: assert property (@(posedge clock) disable iff (reset)
      step && item.first_byte |=> count_ff == CW'(1))
      else $error("first byte did not restart the counter");

endmodule

// ----- hdl/wifi_udp_push_frame_filter_top.sv -----
// Top level of the UDP push frame filter: input register, checker, result
// register and APB configuration port. Depends on wupf_pkg, wupf_csr, wupf_check.
//
// The block takes one frame byte per item and gives exactly one result item per
// byte, so it sustains one item per clock while the result side is not stalled.
// Each item is held in the input register, then checked and loaded into the
// result register, from which its result is offered. A stalled result holds the
// input register, which then holds the input side.
// The single-pass header checker (position compares plus the verdict chain)
// sets the clock path. The last byte of a frame carries the verdict, the first
// failing reason and the captured payload length; payload writes are tentative
// until that verdict says matched.
module wifi_udp_push_frame_filter_top #(
   parameter int CAPTURE_BYTES   = 220,
   parameter int MAX_FRAME_BYTES = 4095
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wupf_pkg::req_item_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wupf_pkg::rsp_item_type              rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wupf_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wupf_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wupf_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import wupf_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_data_ff, in_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;
   rsp_item_type check_result;
   apb_req_type  apb_req;
   logic [15:0]  udp_port;
   logic         out_open;
   logic         step;

   assign apb_req = '{psel: csr_psel, penable: csr_penable, pwrite: csr_pwrite,
                      paddr: csr_paddr, pwdata: csr_pwdata};
   assign csr_pready = 1'b1;

   wupf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .apb_req  (apb_req),
      .prdata   (csr_prdata),
      .udp_port (udp_port)
   );

   wupf_check #(
      .CAPTURE_BYTES   (CAPTURE_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_check (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .item     (in_data_ff),
      .udp_port (udp_port),
      .result   (check_result)
   );

   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end else if (step) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = check_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   matched_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.matched |->
         rsp_data_ff.frame_done && rsp_data_ff.reject_reason == REASON_OK)
      else $error("matched item carries a reject reason");

   verdict_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.frame_done |->
         rsp_data_ff.reject_reason == REASON_OK && !rsp_data_ff.matched &&
         rsp_data_ff.captured_length == 8'd0)
      else $error("verdict fields set before the last byte");

   input_stage_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_open |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost an item while stalled");

endmodule
